// ----- src/char_lcd_nibble_write_sequencer_defines.svh -----
// Assertion macros for the character LCD nibble write sequencer.
// Included by RTL files that carry assertions; no other dependencies.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
`define LCDSEQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LCDSEQ_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define LCDSEQ_ASSERT(lbl, prop, msg)
`define LCDSEQ_NEVER(lbl, expr, msg)
`endif
`endif

// ----- src/lcdseq_pkg.sv -----
// Types, codes and power-up tables for the character LCD nibble write sequencer.
// No dependencies.
`default_nettype none
package lcdseq_pkg;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_NIBBLE = 3'd1;
    localparam logic [2:0] FUNC_BYTE   = 3'd2;
    localparam logic [2:0] FUNC_CHAR   = 3'd3;
    localparam logic [2:0] FUNC_CURSOR = 3'd4;
    localparam logic [2:0] FUNC_INIT   = 3'd5;

    localparam logic [1:0] CFG_ENABLE_PULSE  = 2'd0;
    localparam logic [1:0] CFG_CHAR_SETTLE   = 2'd1;
    localparam logic [1:0] CFG_CURSOR_SETTLE = 2'd2;
    localparam logic [1:0] CFG_POWER_WAIT    = 2'd3;

    localparam int          Q_DEPTH       = 2;
    localparam logic [3:0]  INIT_LAST     = 4'd8;
    localparam logic [3:0]  INIT_NIBBLES  = 4'd4;
    localparam logic [7:0]  CURSOR_BASE   = 8'h80;
    localparam logic [7:0]  RST_PULSE     = 8'd1;
    localparam logic [15:0] RST_CHAR      = 16'd46;
    localparam logic [15:0] RST_CURSOR    = 16'd40;
    localparam logic [15:0] RST_POWER     = 16'd50000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWER,
        PH_HIGH,
        PH_GAP,
        PH_LOW,
        PH_SETTLE
    } t_phase;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_XFER,
        CMD_INIT,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  payload;
        logic [15:0] settle_us;
        logic        row;
        logic [3:0]  column;
    } t_in;

    typedef struct packed {
        logic [3:0] bus_nibble;
        logic       reg_select;
        logic       enable_line;
        logic       busy_res;
        logic       rejected;
    } t_out;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  value;
        logic        rs;
        logic        lone;
        logic [15:0] wait_us;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] init_code(input logic [3:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: init_code = 8'h03;
            4'd3:             init_code = 8'h02;
            4'd4:             init_code = 8'h28;
            4'd5:             init_code = 8'h08;
            4'd6:             init_code = 8'h01;
            4'd7:             init_code = 8'h06;
            default:          init_code = 8'h0C;
        endcase
    endfunction

    function automatic logic [15:0] init_wait(input logic [3:0] k);
        case (k)
            4'd0:                   init_wait = 16'd4100;
            4'd1, 4'd2, 4'd3:       init_wait = 16'd100;
            4'd6:                   init_wait = 16'd3000;
            default:                init_wait = 16'd53;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- src/lcdseq_front.sv -----
// Front end: classifies an incoming word into a sequencer command.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_front (
    input  wire lcdseq_pkg::t_in  i_word,
    input  wire logic [15:0]      i_char_settle_us,
    input  wire logic [15:0]      i_cursor_settle_us,
    output lcdseq_pkg::t_cmd      o_cmd
);

    always_comb begin
        o_cmd.kind    = lcdseq_pkg::CMD_NOP;
        o_cmd.value   = i_word.payload;
        o_cmd.rs      = 1'b0;
        o_cmd.lone    = 1'b0;
        o_cmd.wait_us = i_word.settle_us;
        case (i_word.func)
            lcdseq_pkg::FUNC_TICK: begin
                o_cmd.kind = lcdseq_pkg::CMD_TICK;
            end
            lcdseq_pkg::FUNC_NIBBLE: begin
                o_cmd.kind  = lcdseq_pkg::CMD_XFER;
                o_cmd.value = {4'h0, i_word.payload[3:0]};
                o_cmd.lone  = 1'b1;
            end
            lcdseq_pkg::FUNC_BYTE: begin
                o_cmd.kind = lcdseq_pkg::CMD_XFER;
            end
            lcdseq_pkg::FUNC_CHAR: begin
                o_cmd.kind    = lcdseq_pkg::CMD_XFER;
                o_cmd.rs      = 1'b1;
                o_cmd.wait_us = i_char_settle_us;
            end
            lcdseq_pkg::FUNC_CURSOR: begin
                o_cmd.kind    = lcdseq_pkg::CMD_XFER;
                o_cmd.value   = lcdseq_pkg::CURSOR_BASE
                              | {1'b0, i_word.row, 2'b00, i_word.column};
                o_cmd.wait_us = i_cursor_settle_us;
            end
            lcdseq_pkg::FUNC_INIT: begin
                o_cmd.kind = lcdseq_pkg::CMD_INIT;
            end
            default: begin
                o_cmd.kind = lcdseq_pkg::CMD_NOP;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/lcdseq_fifo.sv -----
// Short command queue between the front end and the sequencer.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire logic               i_push,
    input  wire lcdseq_pkg::t_cmd   i_wdata,
    input  wire logic               i_pop,
    output lcdseq_pkg::t_cmd        o_rdata,
    output lcdseq_pkg::t_q_status   o_status
);

    localparam int DEPTH = lcdseq_pkg::Q_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lcdseq_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule
`default_nettype wire

// ----- src/lcdseq_back.sv -----
// Back end: nibble/enable sequencer, power-up stepper and output register.
// Depends on lcdseq_pkg and the assertion macro header.
`default_nettype none
`include "char_lcd_nibble_write_sequencer_defines.svh"
module lcdseq_back #(
    parameter int WAIT_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire lcdseq_pkg::t_cmd  i_cmd,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_pop,
    input  wire logic [7:0]        i_enable_pulse_us,
    input  wire logic [15:0]       i_power_up_wait_us,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output lcdseq_pkg::t_out       o_data
);

    function automatic logic [WAIT_WIDTH-1:0] clip_wait(input logic [15:0] w);
        logic [WAIT_WIDTH+15:0] wx;
        wx = {{WAIT_WIDTH{1'b0}}, w};
        if (wx > {{16{1'b0}}, {WAIT_WIDTH{1'b1}}}) begin
            clip_wait = '1;
        end else begin
            clip_wait = wx[WAIT_WIDTH-1:0];
        end
    endfunction

    lcdseq_pkg::t_phase     r_phase, n_phase;
    logic [WAIT_WIDTH-1:0]  r_countdown, n_countdown;
    logic [3:0]             r_held_low, n_held_low;
    logic [WAIT_WIDTH-1:0]  r_pending, n_pending;
    logic [3:0]             r_pin_nibble, n_pin_nibble;
    logic                   r_pin_select, n_pin_select;
    logic                   r_pin_enable, n_pin_enable;
    logic [3:0]             r_init_step, n_init_step;
    lcdseq_pkg::t_out       r_out;
    logic                   r_out_valid;

    logic                   busy;
    logic                   rej;
    logic [WAIT_WIDTH-1:0]  cd_dec;
    logic [WAIT_WIDTH-1:0]  pulse;
    logic [WAIT_WIDTH-1:0]  power_wait;
    logic [7:0]             pulse8;
    logic                   finish;
    logic                   init_go;
    logic [3:0]             init_k;
    logic                   start;
    logic [7:0]             st_value;
    logic                   st_rs;
    logic                   st_lone;
    logic [15:0]            st_wait;

    assign o_cmd_pop  = i_cmd_valid && (!r_out_valid || i_ready);
    assign busy       = (r_phase != lcdseq_pkg::PH_IDLE);
    assign cd_dec     = (r_countdown != '0) ? r_countdown - WAIT_WIDTH'(1) : '0;
    assign pulse8     = (i_enable_pulse_us == 8'd0) ? 8'd1 : i_enable_pulse_us;
    assign pulse      = {{(WAIT_WIDTH-8){1'b0}}, pulse8};
    assign power_wait = clip_wait(i_power_up_wait_us);

    always_comb begin
        n_phase      = r_phase;
        n_countdown  = r_countdown;
        n_held_low   = r_held_low;
        n_pending    = r_pending;
        n_pin_nibble = r_pin_nibble;
        n_pin_select = r_pin_select;
        n_pin_enable = r_pin_enable;
        n_init_step  = r_init_step;
        rej          = 1'b0;
        finish       = 1'b0;
        init_go      = 1'b0;
        init_k       = 4'd0;
        start        = 1'b0;
        st_value     = i_cmd.value;
        st_rs        = i_cmd.rs;
        st_lone      = i_cmd.lone;
        st_wait      = i_cmd.wait_us;

        case (i_cmd.kind)
            lcdseq_pkg::CMD_TICK: begin
                if (busy) begin
                    n_countdown = cd_dec;
                    if (cd_dec == '0) begin
                        case (r_phase)
                            lcdseq_pkg::PH_POWER: begin
                                init_go = 1'b1;
                            end
                            lcdseq_pkg::PH_HIGH: begin
                                n_pin_enable = 1'b0;
                                n_phase      = lcdseq_pkg::PH_GAP;
                                n_countdown  = WAIT_WIDTH'(1);
                            end
                            lcdseq_pkg::PH_GAP: begin
                                n_phase      = lcdseq_pkg::PH_LOW;
                                n_pin_nibble = r_held_low;
                                n_pin_enable = 1'b1;
                                n_countdown  = pulse;
                            end
                            lcdseq_pkg::PH_LOW: begin
                                n_pin_enable = 1'b0;
                                if (r_pending == '0) begin
                                    finish = 1'b1;
                                end else begin
                                    n_phase     = lcdseq_pkg::PH_SETTLE;
                                    n_countdown = r_pending;
                                end
                            end
                            default: begin
                                finish = 1'b1;
                            end
                        endcase
                    end
                end
            end
            lcdseq_pkg::CMD_XFER: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    start = 1'b1;
                end
            end
            lcdseq_pkg::CMD_INIT: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_pin_enable = 1'b0;
                    n_pin_select = 1'b0;
                    n_init_step  = 4'd0;
                    n_countdown  = power_wait;
                    if (power_wait == '0) begin
                        init_go = 1'b1;
                    end else begin
                        n_phase = lcdseq_pkg::PH_POWER;
                    end
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            n_pin_enable = 1'b0;
            if (r_init_step >= 4'd1 && r_init_step <= lcdseq_pkg::INIT_LAST) begin
                init_go = 1'b1;
                init_k  = r_init_step;
            end else begin
                n_init_step = 4'd0;
                n_phase     = lcdseq_pkg::PH_IDLE;
                n_countdown = '0;
            end
        end

        if (init_go) begin
            start       = 1'b1;
            st_value    = lcdseq_pkg::init_code(init_k);
            st_rs       = 1'b0;
            st_lone     = (init_k < lcdseq_pkg::INIT_NIBBLES);
            st_wait     = lcdseq_pkg::init_wait(init_k);
            n_init_step = init_k + 4'd1;
        end

        if (start) begin
            n_pin_select = st_rs;
            n_pending    = clip_wait(st_wait);
            n_held_low   = st_value[3:0];
            n_pin_enable = 1'b1;
            n_countdown  = pulse;
            if (st_lone) begin
                n_phase      = lcdseq_pkg::PH_LOW;
                n_pin_nibble = st_value[3:0];
            end else begin
                n_phase      = lcdseq_pkg::PH_HIGH;
                n_pin_nibble = st_value[7:4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lcdseq_pkg::PH_IDLE;
            r_countdown  <= '0;
            r_held_low   <= '0;
            r_pending    <= '0;
            r_pin_nibble <= '0;
            r_pin_select <= 1'b0;
            r_pin_enable <= 1'b0;
            r_init_step  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_phase      <= n_phase;
                r_countdown  <= n_countdown;
                r_held_low   <= n_held_low;
                r_pending    <= n_pending;
                r_pin_nibble <= n_pin_nibble;
                r_pin_select <= n_pin_select;
                r_pin_enable <= n_pin_enable;
                r_init_step  <= n_init_step;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out.bus_nibble  <= n_pin_nibble;
            r_out.reg_select  <= n_pin_select;
            r_out.enable_line <= n_pin_enable;
            r_out.busy_res    <= (n_phase != lcdseq_pkg::PH_IDLE);
            r_out.rejected    <= rej;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `LCDSEQ_ASSERT(a_rej_busy, r_out_valid && r_out.rejected |-> r_out.busy_res, "reject while idle")
    `LCDSEQ_ASSERT(a_en_busy, r_pin_enable |-> r_phase != lcdseq_pkg::PH_IDLE, "enable high when idle")
    `LCDSEQ_ASSERT(a_idle_cd, r_phase == lcdseq_pkg::PH_IDLE |-> r_countdown == '0, "idle with count")
    `LCDSEQ_NEVER(a_step_rng, r_init_step > lcdseq_pkg::INIT_LAST + 4'd1, "init step out of range")
    `LCDSEQ_ASSERT(a_pop_hold, r_out_valid && !i_ready |=> $stable(r_out), "result lost on stall")

endmodule
`default_nettype wire

// ----- src/char_lcd_nibble_write_sequencer.sv -----
// Character LCD 4-bit write sequencer: one result word per accepted word.
// An accepted word is written into the command queue; its result is registered in the back end's output stage.
// Throughput: one word per cycle while i_ready is held high.
// A two-entry command queue sits between classification and sequencing.
// Reset (i_rst_n low, synchronous): idle, pins low, queue empty, registers to defaults.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_fifo, lcdseq_back.
`default_nettype none
module char_lcd_nibble_write_sequencer #(
    parameter int WAIT_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire lcdseq_pkg::t_in  i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output lcdseq_pkg::t_out      o_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [15:0]      i_cfg_data
);

    logic [7:0]            r_enable_pulse_us;
    logic [15:0]           r_char_settle_us;
    logic [15:0]           r_cursor_settle_us;
    logic [15:0]           r_power_up_wait_us;

    lcdseq_pkg::t_cmd      front_cmd;
    lcdseq_pkg::t_cmd      q_cmd;
    lcdseq_pkg::t_q_status q_status;
    logic                  q_push;
    logic                  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_pulse_us  <= lcdseq_pkg::RST_PULSE;
            r_char_settle_us   <= lcdseq_pkg::RST_CHAR;
            r_cursor_settle_us <= lcdseq_pkg::RST_CURSOR;
            r_power_up_wait_us <= lcdseq_pkg::RST_POWER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcdseq_pkg::CFG_ENABLE_PULSE:  r_enable_pulse_us  <= i_cfg_data[7:0];
                lcdseq_pkg::CFG_CHAR_SETTLE:   r_char_settle_us   <= i_cfg_data;
                lcdseq_pkg::CFG_CURSOR_SETTLE: r_cursor_settle_us <= i_cfg_data;
                lcdseq_pkg::CFG_POWER_WAIT:    r_power_up_wait_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ready = !q_status.full;
    assign q_push  = i_valid && o_ready;

    lcdseq_front u_front (
        .i_word             (i_data),
        .i_char_settle_us   (r_char_settle_us),
        .i_cursor_settle_us (r_cursor_settle_us),
        .o_cmd              (front_cmd)
    );

    lcdseq_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_wdata  (front_cmd),
        .i_pop    (q_pop),
        .o_rdata  (q_cmd),
        .o_status (q_status)
    );

    lcdseq_back #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (q_cmd),
        .i_cmd_valid        (!q_status.empty),
        .o_cmd_pop          (q_pop),
        .i_enable_pulse_us  (r_enable_pulse_us),
        .i_power_up_wait_us (r_power_up_wait_us),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_data             (o_data)
    );

endmodule
`default_nettype wire

// ----- tb/char_lcd_nibble_write_sequencer_test.sv -----
// Self-checking testbench for char_lcd_nibble_write_sequencer: a tick-accurate pin predictor
// in a scoreboard class, checked word by word against the result channel.
// Depends on lcdseq_pkg and the char_lcd_nibble_write_sequencer RTL.
`timescale 1ns / 1ps

class lcd_pin_scoreboard;
    logic [7:0]         pulse_len;
    logic [15:0]        char_wait;
    logic [15:0]        cursor_wait;
    logic [15:0]        power_wait;
    lcdseq_pkg::t_phase phase;
    logic [15:0]        count;
    logic [15:0]        settle_left;
    logic [3:0]         low_half;
    logic [3:0]         bus;
    logic               rs;
    logic               en;
    logic [3:0]         init_idx;
    logic [7:0]         init_bytes [9];
    logic [15:0]        init_delays [9];
    lcdseq_pkg::t_out   expected_pins [$];
    int                 errors;

    function new();
        init_bytes = '{8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};
        init_delays = '{16'd4100, 16'd100, 16'd100, 16'd100, 16'd53, 16'd53, 16'd3000,
                        16'd53, 16'd53};
        errors = 0;
        pulse_len = lcdseq_pkg::RST_PULSE;
        char_wait = lcdseq_pkg::RST_CHAR;
        cursor_wait = lcdseq_pkg::RST_CURSOR;
        power_wait = lcdseq_pkg::RST_POWER;
        phase = lcdseq_pkg::PH_IDLE;
        count = '0;
        settle_left = '0;
        low_half = '0;
        bus = '0;
        rs = 1'b0;
        en = 1'b0;
        init_idx = '0;
    endfunction

    function void configure(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            lcdseq_pkg::CFG_ENABLE_PULSE:  pulse_len = data[7:0];
            lcdseq_pkg::CFG_CHAR_SETTLE:   char_wait = data;
            lcdseq_pkg::CFG_CURSOR_SETTLE: cursor_wait = data;
            lcdseq_pkg::CFG_POWER_WAIT:    power_wait = data;
            default: ;
        endcase
    endfunction

    function bit busy();
        return phase != lcdseq_pkg::PH_IDLE;
    endfunction

    function int pending();
        return expected_pins.size();
    endfunction

    function void strobe(input logic [3:0] nib);
        bus = nib;
        en = 1'b1;
        count = (pulse_len == 8'd0) ? 16'd1 : {8'd0, pulse_len};
    endfunction

    function void start_xfer(input logic [7:0] value, input logic sel, input logic lone,
                             input logic [15:0] after);
        rs = sel;
        settle_left = after;
        low_half = value[3:0];
        if (lone) begin
            phase = lcdseq_pkg::PH_LOW;
            strobe(value[3:0]);
        end else begin
            phase = lcdseq_pkg::PH_HIGH;
            strobe(value[7:4]);
        end
    endfunction

    function void start_init_step(input logic [3:0] k);
        if (k > 4'd8)
            k = 4'd8;
        start_xfer(init_bytes[k], 1'b0, k < 4'd4, init_delays[k]);
        init_idx = k + 4'd1;
    endfunction

    function void end_xfer();
        en = 1'b0;
        if (init_idx >= 4'd1 && init_idx <= 4'd8) begin
            start_init_step(init_idx);
        end else begin
            init_idx = '0;
            phase = lcdseq_pkg::PH_IDLE;
            count = '0;
        end
    endfunction

    function void advance_tick();
        if (phase == lcdseq_pkg::PH_IDLE)
            return;
        if (count > 16'd0)
            count = count - 16'd1;
        if (count != 16'd0)
            return;
        case (phase)
            lcdseq_pkg::PH_POWER: start_init_step(4'd0);
            lcdseq_pkg::PH_HIGH: begin
                en = 1'b0;
                phase = lcdseq_pkg::PH_GAP;
                count = 16'd1;
            end
            lcdseq_pkg::PH_GAP: begin
                phase = lcdseq_pkg::PH_LOW;
                strobe(low_half);
            end
            lcdseq_pkg::PH_LOW: begin
                en = 1'b0;
                if (settle_left == 16'd0) begin
                    end_xfer();
                end else begin
                    phase = lcdseq_pkg::PH_SETTLE;
                    count = settle_left;
                end
            end
            default: end_xfer();
        endcase
    endfunction

    function void note_word(input lcdseq_pkg::t_in w);
        lcdseq_pkg::t_out pins;
        logic dropped;
        dropped = 1'b0;
        if (w.func == lcdseq_pkg::FUNC_TICK) begin
            advance_tick();
        end else if (w.func <= lcdseq_pkg::FUNC_INIT) begin
            if (phase != lcdseq_pkg::PH_IDLE) begin
                dropped = 1'b1;
            end else begin
                case (w.func)
                    lcdseq_pkg::FUNC_NIBBLE:
                        start_xfer({4'd0, w.payload[3:0]}, 1'b0, 1'b1, w.settle_us);
                    lcdseq_pkg::FUNC_BYTE:
                        start_xfer(w.payload, 1'b0, 1'b0, w.settle_us);
                    lcdseq_pkg::FUNC_CHAR:
                        start_xfer(w.payload, 1'b1, 1'b0, char_wait);
                    lcdseq_pkg::FUNC_CURSOR:
                        start_xfer(lcdseq_pkg::CURSOR_BASE
                                   | {1'b0, w.row, 2'b00, w.column},
                                   1'b0, 1'b0, cursor_wait);
                    lcdseq_pkg::FUNC_INIT: begin
                        en = 1'b0;
                        rs = 1'b0;
                        init_idx = '0;
                        count = power_wait;
                        if (count == 16'd0)
                            start_init_step(4'd0);
                        else
                            phase = lcdseq_pkg::PH_POWER;
                    end
                    default: ;
                endcase
            end
        end
        pins.bus_nibble = bus;
        pins.reg_select = rs;
        pins.enable_line = en;
        pins.busy_res = (phase != lcdseq_pkg::PH_IDLE);
        pins.rejected = dropped;
        expected_pins.push_back(pins);
    endfunction

    function void check_result(input lcdseq_pkg::t_out got);
        lcdseq_pkg::t_out want;
        if (expected_pins.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            errors++;
            return;
        end
        want = expected_pins.pop_front();
        if (got.bus_nibble !== want.bus_nibble) begin
            $error("bus_nibble: expected %h, got %h", want.bus_nibble, got.bus_nibble);
            errors++;
        end
        if (got.reg_select !== want.reg_select) begin
            $error("reg_select: expected %b, got %b", want.reg_select, got.reg_select);
            errors++;
        end
        if (got.enable_line !== want.enable_line) begin
            $error("enable_line: expected %b, got %b", want.enable_line, got.enable_line);
            errors++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %b, got %b", want.busy_res, got.busy_res);
            errors++;
        end
        if (got.rejected !== want.rejected) begin
            $error("rejected: expected %b, got %b", want.rejected, got.rejected);
            errors++;
        end
    endfunction
endclass

module char_lcd_nibble_write_sequencer_test;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 5000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    lcdseq_pkg::t_in  i_data = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    lcdseq_pkg::t_out o_data;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_idx = lcdseq_pkg::CFG_ENABLE_PULSE;
    logic [15:0]      i_cfg_data = '0;

    lcd_pin_scoreboard pin_board = new();
    bit calm = 1'b0;
    int stall_cycles = 0;

    char_lcd_nibble_write_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic lcdseq_pkg::t_in noise_word();
        lcdseq_pkg::t_in w;
        w.func = lcdseq_pkg::FUNC_TICK;
        w.payload = 8'($urandom);
        w.settle_us = 16'($urandom);
        w.row = 1'($urandom);
        w.column = 4'($urandom);
        return w;
    endfunction

    function automatic lcdseq_pkg::t_in mk(input logic [2:0] func, input logic [7:0] payload,
                                           input logic [15:0] settle, input logic row,
                                           input logic [3:0] column);
        lcdseq_pkg::t_in w;
        w.func = func;
        w.payload = payload;
        w.settle_us = settle;
        w.row = row;
        w.column = column;
        return w;
    endfunction

    task automatic send_word(input lcdseq_pkg::t_in w);
        if (!calm && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk) i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pin_board.note_word(w);
    endtask

    task automatic quiesce();
        while (pin_board.busy()) send_word(noise_word());
        @(negedge i_clk) i_valid <= 1'b0;
        while (pin_board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        pin_board.configure(idx, data);
    endtask

    task automatic set_config(input logic [15:0] pulse, input logic [15:0] char_us,
                              input logic [15:0] cursor_us, input logic [15:0] power_us);
        write_reg(lcdseq_pkg::CFG_ENABLE_PULSE, pulse);
        write_reg(lcdseq_pkg::CFG_CHAR_SETTLE, char_us);
        write_reg(lcdseq_pkg::CFG_CURSOR_SETTLE, cursor_us);
        write_reg(lcdseq_pkg::CFG_POWER_WAIT, power_us);
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    task automatic random_burst(input int count);
        lcdseq_pkg::t_in w;
        int done;
        int r;
        done = 0;
        while (done < count) begin
            w = noise_word();
            r = $urandom_range(0, 99);
            if (pin_board.busy()) begin
                if (r < 84)
                    w.func = lcdseq_pkg::FUNC_TICK;
                else if (r < 97)
                    w.func = 3'($urandom_range(lcdseq_pkg::FUNC_NIBBLE, lcdseq_pkg::FUNC_INIT));
                else
                    w.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
            end else begin
                if (r < 60) begin
                    w.func = 3'($urandom_range(lcdseq_pkg::FUNC_NIBBLE,
                                               lcdseq_pkg::FUNC_CURSOR));
                    w.settle_us = 16'($urandom_range(0, 24));
                end else if (r < 90) begin
                    w.func = lcdseq_pkg::FUNC_TICK;
                end else begin
                    w.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                end
            end
            send_word(w);
            if (w.func <= lcdseq_pkg::FUNC_INIT)
                done++;
        end
    endtask

    // result side: random stalls plus an occasional long hold-off to back up the input
    initial begin
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                hold = $urandom_range(0, 7);
            end else begin
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                pin_board.check_result(o_data);
                seen++;
                if (!calm && seen < 2000 && seen % 500 == 250)
                    hold = 150 + $urandom_range(0, 50);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("char_lcd_nibble_write_sequencer test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // defaults after reset
        send_word(mk(lcdseq_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 4'h0));
        send_word(mk(FUNC_SPARE_LO, 8'hFF, 16'hFFFF, 1'b1, 4'hF));
        send_word(mk(FUNC_SPARE_HI, 8'h00, 16'h0000, 1'b0, 4'h0));
        send_word(mk(lcdseq_pkg::FUNC_NIBBLE, 8'hFF, 16'h0000, 1'b0, 4'h0));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_BYTE, 8'hA5, 16'd3, 1'b0, 4'h0));
        send_word(mk(lcdseq_pkg::FUNC_CHAR, 8'h41, 16'd0, 1'b0, 4'h0));
        send_word(mk(lcdseq_pkg::FUNC_CURSOR, 8'h00, 16'd0, 1'b1, 4'h3));
        send_word(mk(lcdseq_pkg::FUNC_INIT, 8'h00, 16'd0, 1'b0, 4'h0));
        send_word(mk(lcdseq_pkg::FUNC_NIBBLE, 8'h0C, 16'd9, 1'b0, 4'h0));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_CHAR, 8'hFF, 16'h0000, 1'b0, 4'h0));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_CHAR, 8'h00, 16'h0000, 1'b0, 4'h0));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_CURSOR, 8'h00, 16'h0000, 1'b1, 4'hF));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_CURSOR, 8'hFF, 16'hFFFF, 1'b0, 4'h0));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_BYTE, 8'hFF, 16'h0000, 1'b0, 4'h0));
        quiesce();

        // zero pulse (masked upper byte), zero settles
        set_config(16'hFF00, 16'd0, 16'd0, 16'd0);
        send_word(mk(lcdseq_pkg::FUNC_CHAR, 8'h5A, 16'h0000, 1'b0, 4'h0));
        quiesce();
        send_word(mk(lcdseq_pkg::FUNC_CURSOR, 8'h00, 16'h0000, 1'b1, 4'hA));
        quiesce();

        // widest enable pulse
        set_config(16'h00FF, 16'd2, 16'd1, 16'd3);
        send_word(mk(lcdseq_pkg::FUNC_NIBBLE, 8'h07, 16'd5, 1'b0, 4'h0));
        quiesce();

        for (int chunk = 0; chunk < 4; chunk++) begin
            set_config({8'($urandom), 8'($urandom_range(0, 5))},
                       16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                       16'($urandom_range(0, 300)));
            if (chunk == 3)
                calm = 1'b1;
            random_burst(140);
            quiesce();
        end

        // zero pulse and a short power-up wait; the run ends in the first init wait
        set_config(16'hFF00, 16'hFFFF, 16'hFFFF, 16'd2);
        send_word(mk(lcdseq_pkg::FUNC_INIT, 8'h00, 16'h0000, 1'b0, 4'h0));
        random_burst(40);

        @(negedge i_clk) i_valid <= 1'b0;
        while (pin_board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pin_board.errors == 0)
            $display("char_lcd_nibble_write_sequencer test passed");
        else
            $display("char_lcd_nibble_write_sequencer test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/lcdseq_pkg.sv
src/lcdseq_front.sv
src/lcdseq_fifo.sv
src/lcdseq_back.sv
src/char_lcd_nibble_write_sequencer.sv
tb/char_lcd_nibble_write_sequencer_test.sv
